>>> hw/rtl/sckt_pkg.sv
`default_nettype none

package sckt_pkg;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_E1       = 2'd1;
   localparam logic [1:0] ST_UNMAPPED = 2'd2;

   // Special key codes
   localparam logic [7:0] KC_NONE   = 8'd0;
   localparam logic [7:0] KC_LEFT   = 8'd128;
   localparam logic [7:0] KC_RIGHT  = 8'd129;
   localparam logic [7:0] KC_UP     = 8'd130;
   localparam logic [7:0] KC_DOWN   = 8'd131;
   localparam logic [7:0] KC_RCTRL  = 8'd132;
   localparam logic [7:0] KC_RALT   = 8'd133;
   localparam logic [7:0] KC_BKSP   = 8'd134;
   localparam logic [7:0] KC_ENTER  = 8'd135;
   localparam logic [7:0] KC_ESC    = 8'd136;
   localparam logic [7:0] KC_LSHIFT = 8'd137;
   localparam logic [7:0] KC_RSHIFT = 8'd138;
   localparam logic [7:0] KC_LCTRL  = 8'd139;
   localparam logic [7:0] KC_LALT   = 8'd140;
   localparam logic [7:0] KC_CAPS   = 8'd141;

   // Key-down map is indexed by key code; every mapped key has its own code
   localparam int KEY_COUNT = 142;

   // Queue between classifier and executer
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [15:0] scan_code;
      logic        break_flag;
      logic        extended_e0;
      logic        prefix_e1;
      logic [63:0] event_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_status;
      logic [7:0]  key_code;
      logic [6:0]  text_char;
      logic        pressed;
      logic        is_repeat;
      logic        shift_on;
      logic        control_on;
      logic        alt_on;
      logic        caps_on;
      logic [63:0] out_time;
   } rsp_type;

   // Classified event, as queued for the back end
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  key_code;
      logic        break_flag;
      logic [63:0] event_time;
   } event_type;

   // Set-1 make code to key code; zero when unmapped
   function automatic logic [7:0] map_code(input logic [15:0] sc, input logic ext);
      logic [7:0] kc;
      kc = KC_NONE;
      if (sc[15:8] == 8'd0) begin
         if (ext) begin
            unique case (sc[7:0])
               8'h4b:   kc = KC_LEFT;
               8'h4d:   kc = KC_RIGHT;
               8'h48:   kc = KC_UP;
               8'h50:   kc = KC_DOWN;
               8'h1d:   kc = KC_RCTRL;
               8'h38:   kc = KC_RALT;
               default: kc = KC_NONE;
            endcase
         end else begin
            unique case (sc[7:0])
               8'h0e: kc = KC_BKSP;
               8'h1c: kc = KC_ENTER;
               8'h01: kc = KC_ESC;
               8'h39: kc = 8'd32;
               8'h2a: kc = KC_LSHIFT;
               8'h36: kc = KC_RSHIFT;
               8'h1d: kc = KC_LCTRL;
               8'h38: kc = KC_LALT;
               8'h3a: kc = KC_CAPS;
               8'h1e: kc = 8'h61;
               8'h30: kc = 8'h62;
               8'h2e: kc = 8'h63;
               8'h20: kc = 8'h64;
               8'h12: kc = 8'h65;
               8'h21: kc = 8'h66;
               8'h22: kc = 8'h67;
               8'h23: kc = 8'h68;
               8'h17: kc = 8'h69;
               8'h24: kc = 8'h6a;
               8'h25: kc = 8'h6b;
               8'h26: kc = 8'h6c;
               8'h32: kc = 8'h6d;
               8'h31: kc = 8'h6e;
               8'h18: kc = 8'h6f;
               8'h19: kc = 8'h70;
               8'h10: kc = 8'h71;
               8'h13: kc = 8'h72;
               8'h1f: kc = 8'h73;
               8'h14: kc = 8'h74;
               8'h16: kc = 8'h75;
               8'h2f: kc = 8'h76;
               8'h11: kc = 8'h77;
               8'h2d: kc = 8'h78;
               8'h15: kc = 8'h79;
               8'h2c: kc = 8'h7a;
               8'h02: kc = 8'h31;
               8'h03: kc = 8'h32;
               8'h04: kc = 8'h33;
               8'h05: kc = 8'h34;
               8'h06: kc = 8'h35;
               8'h07: kc = 8'h36;
               8'h08: kc = 8'h37;
               8'h09: kc = 8'h38;
               8'h0a: kc = 8'h39;
               8'h0b: kc = 8'h30;
               8'h29: kc = 8'h60;
               8'h0c: kc = 8'h2d;
               8'h0d: kc = 8'h3d;
               8'h1a: kc = 8'h5b;
               8'h1b: kc = 8'h5d;
               8'h2b: kc = 8'h5c;
               8'h27: kc = 8'h3b;
               8'h28: kc = 8'h27;
               8'h33: kc = 8'h2c;
               8'h34: kc = 8'h2e;
               8'h35: kc = 8'h2f;
               default: kc = KC_NONE;
            endcase
         end
      end
      return kc;
   endfunction

   // Text for a pressed key under the given shift and caps state
   function automatic logic [6:0] text_of(input logic [7:0] kc, input logic sh,
                                          input logic caps);
      logic [7:0] t;
      if (kc >= 8'h61 && kc <= 8'h7a) begin
         t = (sh != caps) ? kc - 8'd32 : kc;
      end else begin
         case (kc)
            8'h60:   t = sh ? 8'h7e : kc;
            8'h31:   t = sh ? 8'h21 : kc;
            8'h32:   t = sh ? 8'h40 : kc;
            8'h33:   t = sh ? 8'h23 : kc;
            8'h34:   t = sh ? 8'h24 : kc;
            8'h35:   t = sh ? 8'h25 : kc;
            8'h36:   t = sh ? 8'h5e : kc;
            8'h37:   t = sh ? 8'h26 : kc;
            8'h38:   t = sh ? 8'h2a : kc;
            8'h39:   t = sh ? 8'h28 : kc;
            8'h30:   t = sh ? 8'h29 : kc;
            8'h2d:   t = sh ? 8'h5f : kc;
            8'h3d:   t = sh ? 8'h2b : kc;
            8'h5b:   t = sh ? 8'h7b : kc;
            8'h5d:   t = sh ? 8'h7d : kc;
            8'h5c:   t = sh ? 8'h7c : kc;
            8'h3b:   t = sh ? 8'h3a : kc;
            8'h27:   t = sh ? 8'h22 : kc;
            8'h2c:   t = sh ? 8'h3c : kc;
            8'h2e:   t = sh ? 8'h3e : kc;
            8'h2f:   t = sh ? 8'h3f : kc;
            default: t = (kc >= 8'd32 && kc < 8'd127) ? kc : 8'd0;
         endcase
      end
      return t[6:0];
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/scan_code_key_translator.sv
// A request transfer writes a queue slot; the back end then takes the queue head into the
// result register, from which the result is on the rsp ports until it is popped.
// Throughput: one event per cycle while results are popped, via a 4-entry queue.
// Key-down map lives in flip-flops indexed by key code, so one event per cycle
// reads and updates it with no hazard.
// Reset (synchronous, active high) clears the queue, result valid flag, modifiers,
// caps latch and key-down map; req_full is high while reset is held.
`default_nettype none

module scan_code_key_translator
   import sckt_pkg::*;
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    req_push,
   input  wire  req_type req_data,
   output logic          req_full,
   output logic          rsp_empty,
   input  wire  logic    rsp_pop,
   output rsp_type       rsp_data
);

   logic      q_full, q_push, q_pop, q_empty;
   event_type q_in, q_head;

   sckt_front u_front (
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   sckt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   sckt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> hw/rtl/sckt_front.sv
`default_nettype none

module sckt_front
   import sckt_pkg::*;
(
   input  wire  logic      reset,
   input  wire  logic      req_push,
   input  wire  req_type   req_data,
   output logic            req_full,
   input  wire  logic      q_full,
   output logic            q_push,
   output event_type       q_data
);

   logic [7:0] kc;

   // Classify: E1 first, then table lookup
   always_comb begin
      kc = map_code(req_data.scan_code, req_data.extended_e0);
      q_data.break_flag = req_data.break_flag;
      q_data.event_time = req_data.event_time;
      if (req_data.prefix_e1) begin
         q_data.status   = ST_E1;
         q_data.key_code = KC_NONE;
      end else if (kc == KC_NONE) begin
         q_data.status   = ST_UNMAPPED;
         q_data.key_code = KC_NONE;
      end else begin
         q_data.status   = ST_OK;
         q_data.key_code = kc;
      end
   end

   // Transfer into the queue; held off during reset
   assign req_full = q_full | reset;
   assign q_push   = req_push & ~req_full;

endmodule

`default_nettype wire

>>> hw/rtl/sckt_queue.sv
`default_nettype none

module sckt_queue
   import sckt_pkg::*;
(
   input  wire  logic      clock,
   input  wire  logic      reset,
   input  wire  logic      push,
   input  wire  event_type push_data,
   output logic            full,
   input  wire  logic      pop,
   output logic            empty,
   output event_type       head
);

   event_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/sckt_back.sv
`default_nettype none

module sckt_back
   import sckt_pkg::*;
(
   input  wire  logic      clock,
   input  wire  logic      reset,
   input  wire  logic      q_empty,
   input  wire  event_type q_head,
   output logic            q_pop,
   output logic            rsp_empty,
   input  wire  logic      rsp_pop,
   output rsp_type         rsp_data
);

   logic [KEY_COUNT-1:0] down_ff, down_in;
   logic                 shift_ff, shift_in;
   logic                 ctrl_ff, ctrl_in;
   logic                 alt_ff, alt_in;
   logic                 caps_ff, caps_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;
   logic                 ok, rel, rep, advance;
   logic [7:0]           kc;

   // Take the head whenever the output register is free or being drained
   assign advance = ~q_empty & (~out_valid_ff | rsp_pop);
   assign q_pop   = advance;

   // Execute one event against the key state
   always_comb begin
      kc  = q_head.key_code;
      ok  = (q_head.status == ST_OK);
      rel = q_head.break_flag;
      rep = ok & ~rel & down_ff[kc];

      down_in  = down_ff;
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      alt_in   = alt_ff;
      caps_in  = caps_ff;

      if (advance && ok) begin
         down_in[kc] = ~rel;
         if (kc == KC_LSHIFT || kc == KC_RSHIFT) begin
            shift_in = ~rel;
         end
         if (kc == KC_LCTRL || kc == KC_RCTRL) begin
            ctrl_in = ~rel;
         end
         if (kc == KC_LALT || kc == KC_RALT) begin
            alt_in = ~rel;
         end
         // Caps lock toggles only on a fresh press
         if (kc == KC_CAPS && !rel && !rep) begin
            caps_in = ~caps_ff;
         end
      end

      out_in.result_status = q_head.status;
      out_in.key_code      = kc;
      out_in.text_char     = (ok && !rel) ? text_of(kc, shift_in, caps_in) : 7'd0;
      out_in.pressed       = ok & ~rel;
      out_in.is_repeat     = rep;
      out_in.shift_on      = shift_in;
      out_in.control_on    = ctrl_in;
      out_in.alt_on        = alt_in;
      out_in.caps_on       = caps_in;
      out_in.out_time      = q_head.event_time;

      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff      <= '0;
         shift_ff     <= 1'b0;
         ctrl_ff      <= 1'b0;
         alt_ff       <= 1'b0;
         caps_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         down_ff      <= down_in;
         shift_ff     <= shift_in;
         ctrl_ff      <= ctrl_in;
         alt_ff       <= alt_in;
         caps_ff      <= caps_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
